>>> hdl/fbrgba_pkg.sv
`timescale 1ns / 1ps

package fbrgba_pkg;

    // palette
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int PAL_DATA_W = 24;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BITS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BITS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BITS   = 3'd6;

    // pixel size codes
    localparam logic [2:0] PB_PALETTE = 3'd1;
    localparam logic [2:0] PB_16BIT   = 3'd2;
    localparam logic [2:0] PB_24BIT   = 3'd3;

    // reset values
    localparam logic [2:0] RST_PIXEL_BYTES = 3'd4;
    localparam logic [4:0] RST_RED_SHIFT   = 5'd16;
    localparam logic [4:0] RST_GREEN_SHIFT = 5'd8;
    localparam logic [4:0] RST_BLUE_SHIFT  = 5'd0;
    localparam logic [3:0] RST_RED_BITS    = 4'd5;
    localparam logic [3:0] RST_GREEN_BITS  = 4'd6;
    localparam logic [3:0] RST_BLUE_BITS   = 4'd5;

    localparam logic [7:0] ALPHA = 8'hFF;

    // scaling datapath
    localparam int MASK_W = 15;
    localparam int SCALED_W = MASK_W + 8;
    localparam int RECIP_W = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W = SCALED_W + RECIP_W;

    typedef logic [7:0] comp_t;

    function automatic logic [MASK_W-1:0] field_mask(input logic [3:0] bits);
        return MASK_W'((16'd1 << bits) - 16'd1);
    endfunction

    // floor(2^24 / (2^bits - 1)); quotient estimate is low by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] bits);
        logic [RECIP_W-1:0] m;
        case (bits)
            4'd1:    m = 25'd16777216;
            4'd2:    m = 25'd5592405;
            4'd3:    m = 25'd2396745;
            4'd4:    m = 25'd1118481;
            4'd5:    m = 25'd541200;
            4'd6:    m = 25'd266305;
            4'd7:    m = 25'd132104;
            4'd8:    m = 25'd65793;
            4'd9:    m = 25'd32832;
            4'd10:   m = 25'd16400;
            4'd11:   m = 25'd8196;
            4'd12:   m = 25'd4097;
            4'd13:   m = 25'd2048;
            4'd14:   m = 25'd1024;
            4'd15:   m = 25'd512;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/fbrgba_ram.sv
`timescale 1ns / 1ps

module fbrgba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/framebuffer_pixel_to_rgba_top.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_stall  | func, raw_pixel, entry_index, entry_red/green/blue
// out      | out_valid / out_stall| rgba_word
// cfg      | cfg_we               | cfg_index, cfg_data
//
// one word per clock while out_stall lets it; a conversion taken at an edge passes through the
// ram read with stage 1 at that edge, quotient estimate to stage 2, correction to output
// palette writes go to the ram at the accept edge and give no word
// reset clears control and configuration only; palette entries hold garbage until written
// out_stall backs up stage by stage; in_stall rises only when all three stages are full
`timescale 1ns / 1ps

module framebuffer_pixel_to_rgba_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [31:0]                       raw_pixel,
    input  logic [7:0]                        entry_index,
    input  logic [7:0]                        entry_red,
    input  logic [7:0]                        entry_green,
    input  logic [7:0]                        entry_blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       rgba_word,
    input  logic                              cfg_we,
    input  logic [fbrgba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbrgba_pkg::CFG_DATA_W-1:0] cfg_data
);

    import fbrgba_pkg::*;

    // configuration, lane 0 red, 1 green, 2 blue
    logic [2:0] pixel_bytes_reg, pixel_bytes_next;
    logic [4:0] shift_reg [3];
    logic [4:0] shift_next [3];
    logic [3:0] bits_reg [3];
    logic [3:0] bits_next [3];

    // handshake
    logic out_free, s2_free, s1_free;
    logic in_acc, conv_acc, wr_acc;

    // palette ram
    logic                  ram_we, ram_re;
    logic [PAL_DATA_W-1:0] ram_rdata;

    // stage 1
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_pixel_reg, s1_pixel_next;
    logic [31:0] s1_q32;
    logic        s1_pal_ok;
    logic [PAL_DATA_W-1:0] s1_pal;
    logic [MASK_W-1:0]   s1_mask [3];
    logic [MASK_W-1:0]   s1_v [3];
    logic [SCALED_W-1:0] s1_x [3];
    logic [PROD_W-1:0]   s1_prod [3];
    comp_t               s1_field [3];
    comp_t               s1_direct [3];

    // stage 2
    logic                s2_valid_reg, s2_valid_next;
    logic                s2_scaled_reg, s2_scaled_next;
    comp_t               s2_q_reg [3];
    comp_t               s2_q_next [3];
    logic [SCALED_W-1:0] s2_x_reg [3];
    logic [SCALED_W-1:0] s2_x_next [3];
    comp_t               s2_direct_reg [3];
    comp_t               s2_direct_next [3];
    logic [MASK_W-1:0]   s2_mask [3];
    logic [SCALED_W-1:0] s2_back [3];
    logic [SCALED_W-1:0] s2_rem [3];
    comp_t               s2_comp [3];
    comp_t               s2_final [3];

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;

    always_comb
    begin
        pixel_bytes_next = pixel_bytes_reg;
        for (int c = 0; c < 3; c++)
        begin
            shift_next[c] = shift_reg[c];
            bits_next[c] = bits_reg[c];
        end
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_BYTES: pixel_bytes_next = cfg_data[2:0];
                REG_RED_SHIFT:   shift_next[0] = cfg_data[4:0];
                REG_GREEN_SHIFT: shift_next[1] = cfg_data[4:0];
                REG_BLUE_SHIFT:  shift_next[2] = cfg_data[4:0];
                REG_RED_BITS:    bits_next[0] = cfg_data[3:0];
                REG_GREEN_BITS:  bits_next[1] = cfg_data[3:0];
                REG_BLUE_BITS:   bits_next[2] = cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg <= RST_PIXEL_BYTES;
            shift_reg[0] <= RST_RED_SHIFT;
            shift_reg[1] <= RST_GREEN_SHIFT;
            shift_reg[2] <= RST_BLUE_SHIFT;
            bits_reg[0] <= RST_RED_BITS;
            bits_reg[1] <= RST_GREEN_BITS;
            bits_reg[2] <= RST_BLUE_BITS;
        end
        else
        begin
            pixel_bytes_reg <= pixel_bytes_next;
            shift_reg <= shift_next;
            bits_reg <= bits_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;

    assign in_acc   = in_valid && !in_stall;
    assign conv_acc = in_acc && !func;
    assign wr_acc   = in_acc && func;

    // a read in the cycle after a write to the same entry already sees the new data
    assign ram_we = wr_acc && ({1'b0, entry_index} < PAL_LIMIT);
    assign ram_re = conv_acc;

    fbrgba_ram #(
        .WIDTH (PAL_DATA_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_index[PAL_IDX_W-1:0]),
        .wdata ({entry_red, entry_green, entry_blue}),
        .re    (ram_re),
        .raddr (raw_pixel[PAL_IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // stage 1: field extraction, palette select, v*255 times reciprocal
    always_comb
    begin
        s1_valid_next = s1_free ? conv_acc : s1_valid_reg;
        s1_pixel_next = (s1_free && conv_acc) ? raw_pixel : s1_pixel_reg;

        s1_q32 = (pixel_bytes_reg == PB_24BIT) ? {8'd0, s1_pixel_reg[23:0]} : s1_pixel_reg;
        s1_pal_ok = ({1'b0, s1_pixel_reg[7:0]} < PAL_LIMIT);
        s1_pal = s1_pal_ok ? ram_rdata : '0;

        for (int c = 0; c < 3; c++)
        begin
            s1_mask[c] = field_mask(bits_reg[c]);
            s1_v[c] = MASK_W'(s1_pixel_reg[15:0] >> shift_reg[c]) & s1_mask[c];
            s1_x[c] = {s1_v[c], 8'd0} - SCALED_W'(s1_v[c]);
            s1_prod[c] = PROD_W'(s1_x[c]) * PROD_W'(recip(bits_reg[c]));
            s1_field[c] = 8'(s1_q32 >> shift_reg[c]);
            s1_direct[c] = (pixel_bytes_reg == PB_PALETTE) ? s1_pal[(2 - c) * 8 +: 8]
                                                            : s1_field[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pixel_reg <= s1_pixel_next;
    end

    // stage 2: correct quotient estimate (low by at most one)
    always_comb
    begin
        s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;
        s2_scaled_next = s2_scaled_reg;
        if (s2_free && s1_valid_reg)
        begin
            s2_scaled_next = (pixel_bytes_reg == PB_16BIT);
        end

        for (int c = 0; c < 3; c++)
        begin
            s2_q_next[c] = s2_q_reg[c];
            s2_x_next[c] = s2_x_reg[c];
            s2_direct_next[c] = s2_direct_reg[c];
            if (s2_free && s1_valid_reg)
            begin
                s2_q_next[c] = s1_prod[c][RECIP_SHIFT +: 8];
                s2_x_next[c] = s1_x[c];
                s2_direct_next[c] = s1_direct[c];
            end

            s2_mask[c] = field_mask(bits_reg[c]);
            s2_back[c] = SCALED_W'(SCALED_W'(s2_q_reg[c]) * SCALED_W'(s2_mask[c]));
            s2_rem[c] = s2_x_reg[c] - s2_back[c];
            if (s2_mask[c] == '0)
            begin
                s2_comp[c] = 8'd0;
            end
            else if (s2_rem[c] >= SCALED_W'(s2_mask[c]))
            begin
                s2_comp[c] = s2_q_reg[c] + 8'd1;
            end
            else
            begin
                s2_comp[c] = s2_q_reg[c];
            end
            s2_final[c] = s2_scaled_reg ? s2_comp[c] : s2_direct_reg[c];
        end

        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;
        out_word_next = out_word_reg;
        if (out_free && s2_valid_reg)
        begin
            out_word_next = {s2_final[0], s2_final[1], s2_final[2], ALPHA};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_scaled_reg <= s2_scaled_next;
        s2_q_reg <= s2_q_next;
        s2_x_reg <= s2_x_next;
        s2_direct_reg <= s2_direct_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign rgba_word = out_word_reg;

`ifndef SYNTH
    // a blocked stage 1 word keeps its pixel
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_pixel_reg))
        else $error("stage 1 word lost while blocked");

    // ram data for a blocked word must not be overwritten by a new read
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |-> !ram_re)
        else $error("palette read issued while stage 1 blocked");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("output word appeared without stage 2 word");

    // remainder after the estimate stays below twice the mask
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_scaled_reg |->
            (s2_mask[0] == '0 || s2_rem[0] < {s2_mask[0], 1'b0}) &&
            (s2_mask[1] == '0 || s2_rem[1] < {s2_mask[1], 1'b0}) &&
            (s2_mask[2] == '0 || s2_rem[2] < {s2_mask[2], 1'b0}))
        else $error("scale quotient estimate off by more than one");
`endif

endmodule
